// ----- rtl/mpct_pkg.sv -----
package mpct_pkg;

  // Default cursor coordinate width
  localparam int COORD_BITS_DEF = 12;

  // Screen size register width
  localparam int SIZE_BITS = 12;

  // Configuration register indexes
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  // Screen size defaults, also used when a size of zero is written
  localparam logic [SIZE_BITS-1:0] DEF_WIDTH  = 12'd640;
  localparam logic [SIZE_BITS-1:0] DEF_HEIGHT = 12'd480;

  // Controller status bits
  localparam int STAT_DATA_BIT = 0;
  localparam int STAT_AUX_BIT  = 5;

  // Packet header bits
  localparam int HDR_SYNC_BIT = 3;
  localparam int HDR_XOVF_BIT = 6;
  localparam int HDR_YOVF_BIT = 7;
  localparam int BTN_BITS     = 3;

  // Saturation limits of an 8-bit delta
  localparam logic [7:0] DELTA_MIN = 8'h80;
  localparam logic [7:0] DELTA_MAX = 8'h7F;

  // Byte position within a packet
  localparam logic [1:0] POS_HEAD   = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;

  // One complete packet
  typedef struct packed {
    logic [7:0] header;
    logic [7:0] second;
    logic [7:0] third;
  } pkt_t;

endpackage

// ----- rtl/mpct_frame.sv -----
module mpct_frame (
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  logic [7:0]   status_byte,
  input  logic [7:0]   data_byte,
  input  logic         advance,
  output logic         pkt_valid,
  output mpct_pkg::pkt_t pkt
);
  import mpct_pkg::*;

  logic       s1_valid;
  logic [7:0] s1_status;
  logic [7:0] s1_data;
  logic [1:0] byte_position;
  logic [1:0] byte_position_next;
  logic [7:0] header_byte;
  logic [7:0] second_byte;
  logic       taken;
  logic       go;
  logic       in_fire;

  // Input register frees up whenever its beat moves on
  assign in_ready = !s1_valid || advance;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status <= status_byte;
      s1_data   <= data_byte;
    end
  end

  // Only data-present aux bytes count
  assign taken = s1_valid && s1_status[STAT_DATA_BIT] && s1_status[STAT_AUX_BIT];
  assign go    = taken && advance;

  // Packet framing
  always_comb begin
    case (byte_position)
      POS_SECOND: byte_position_next = POS_THIRD;
      POS_THIRD:  byte_position_next = POS_HEAD;
      default: begin
        byte_position_next = s1_data[HDR_SYNC_BIT] ? POS_SECOND : POS_HEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_HEAD;
    end else if (go) begin
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (go && byte_position == POS_SECOND) begin
      second_byte <= s1_data;
    end
    if (go && byte_position != POS_SECOND && byte_position != POS_THIRD
        && s1_data[HDR_SYNC_BIT]) begin
      header_byte <= s1_data;
    end
  end

  // Third byte completes the packet
  assign pkt_valid  = taken && (byte_position == POS_THIRD);
  assign pkt.header = header_byte;
  assign pkt.second = second_byte;
  assign pkt.third  = s1_data;

endmodule

// ----- rtl/mpct_cursor.sv -----
module mpct_cursor #(
  parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pkt_valid,
  input  mpct_pkg::pkt_t                pkt,
  input  logic [mpct_pkg::SIZE_BITS-1:0] screen_width,
  input  logic [mpct_pkg::SIZE_BITS-1:0] screen_height,
  output logic                          advance,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [COORD_BITS-1:0]         cursor_x,
  output logic [COORD_BITS-1:0]         cursor_y,
  output logic [mpct_pkg::BTN_BITS-1:0] button_bits,
  output logic signed [7:0]             delta_x,
  output logic signed [8:0]             delta_y
);
  import mpct_pkg::*;

  // Working width covers position plus delta and the screen limit
  localparam int SW = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;

  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [COORD_BITS-1:0] pos_x_next;
  logic [COORD_BITS-1:0] pos_y_next;
  logic [7:0]            dx;
  logic [7:0]            dy;
  logic [8:0]            ndy;
  logic signed [SW-1:0]  vx;
  logic signed [SW-1:0]  vy;
  logic                  go;

  // Clamp v to [0, min(size-1, 2^COORD_BITS-1)], zero size picks dflt
  function automatic logic [COORD_BITS-1:0] clamp_coord(
    input logic signed [SW-1:0]  v,
    input logic [SIZE_BITS-1:0]  size,
    input logic [SIZE_BITS-1:0]  dflt
  );
    logic [SIZE_BITS-1:0] sz;
    logic signed [SW-1:0] mx;
    logic signed [SW-1:0] lim;
    logic signed [SW-1:0] r;
    sz  = (size == '0) ? dflt : size;
    mx  = $signed({{(SW-SIZE_BITS){1'b0}}, sz}) - $signed({{(SW-1){1'b0}}, 1'b1});
    lim = $signed({{(SW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}});
    if (mx > lim) begin
      mx = lim;
    end
    if (v < 0) begin
      r = '0;
    end else if (v > mx) begin
      r = mx;
    end else begin
      r = v;
    end
    return r[COORD_BITS-1:0];
  endfunction

  // Result register is free when empty or being drained
  assign advance = !out_valid || out_ready;
  assign go      = pkt_valid && advance;

  // Deltas with overflow saturation by sign
  assign dx  = pkt.header[HDR_XOVF_BIT] ? (pkt.second[7] ? DELTA_MIN : DELTA_MAX) : pkt.second;
  assign dy  = pkt.header[HDR_YOVF_BIT] ? (pkt.third[7] ? DELTA_MIN : DELTA_MAX) : pkt.third;
  assign ndy = 9'd0 - {dy[7], dy};

  // New position: X gains dx, Y loses dy
  assign vx = $signed({{(SW-COORD_BITS){1'b0}}, pos_x}) + $signed({{(SW-8){dx[7]}}, dx});
  assign vy = $signed({{(SW-COORD_BITS){1'b0}}, pos_y}) + $signed({{(SW-9){ndy[8]}}, ndy});

  assign pos_x_next = clamp_coord(vx, screen_width, DEF_WIDTH);
  assign pos_y_next = clamp_coord(vy, screen_height, DEF_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= COORD_BITS'(DEF_WIDTH >> 1);
      pos_y <= COORD_BITS'(DEF_HEIGHT >> 1);
    end else if (go) begin
      pos_x <= pos_x_next;
      pos_y <= pos_y_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= pkt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      cursor_x    <= pos_x_next;
      cursor_y    <= pos_y_next;
      button_bits <= pkt.header[BTN_BITS-1:0];
      delta_x     <= $signed(dx);
      delta_y     <= $signed(ndy);
    end
  end

endmodule

// ----- rtl/mouse_packet_cursor_tracker.sv -----
// Mouse packet decoder with cursor tracking. Each input beat is a controller
// status byte with its data byte; beats without both the data-present and aux
// status bits are dropped, and a packet header without its sync bit is skipped.
// Every third valid byte completes a packet and yields one result: the cursor
// position clamped to the screen (width/height of zero mean 640x480), the
// buttons and the saturated deltas (delta_y is already negated to screen
// direction). One beat is accepted per clock unless the input register is held;
// a beat passes the input register, then the position update with clamp into
// the result register. While a result waits at the output, only an empty input
// register accepts a beat. The user must write screen size registers through
// the cfg port only while no packet is in flight; the block does not enforce it.
module mouse_packet_cursor_tracker #(
  parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [mpct_pkg::SIZE_BITS-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     status_byte,
  input  logic [7:0]                     data_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [COORD_BITS-1:0]          cursor_x,
  output logic [COORD_BITS-1:0]          cursor_y,
  output logic [mpct_pkg::BTN_BITS-1:0]  button_bits,
  output logic signed [7:0]              delta_x,
  output logic signed [8:0]              delta_y
);
  import mpct_pkg::*;

  logic [SIZE_BITS-1:0] screen_width;
  logic [SIZE_BITS-1:0] screen_height;
  logic                 advance;
  logic                 pkt_valid;
  pkt_t                 pkt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= DEF_WIDTH;
      screen_height <= DEF_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data;
        default: ;
      endcase
    end
  end

  mpct_frame u_frame (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .status_byte (status_byte),
    .data_byte   (data_byte),
    .advance     (advance),
    .pkt_valid   (pkt_valid),
    .pkt         (pkt)
  );

  mpct_cursor #(
    .COORD_BITS (COORD_BITS)
  ) u_cursor (
    .clk           (clk),
    .rst           (rst),
    .pkt_valid     (pkt_valid),
    .pkt           (pkt),
    .screen_width  (screen_width),
    .screen_height (screen_height),
    .advance       (advance),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .cursor_x      (cursor_x),
    .cursor_y      (cursor_y),
    .button_bits   (button_bits),
    .delta_x       (delta_x),
    .delta_y       (delta_y)
  );

endmodule

// ----- rtl/mpct_checker.sv -----
module mpct_checker #(
  parameter int COORD_BITS = mpct_pkg::COORD_BITS_DEF
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [COORD_BITS-1:0]         cursor_x,
  input logic [COORD_BITS-1:0]         cursor_y,
  input logic [mpct_pkg::BTN_BITS-1:0] button_bits,
  input logic signed [8:0]             delta_y
);
  import mpct_pkg::*;

  // A stalled result beat holds its cursor, button and delta_y payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cursor_x) && $stable(cursor_y)
      && $stable(button_bits) && $stable(delta_y))
    else $error("result beat changed while stalled");

  // Reset empties the pipeline and opens the input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // Negated 8-bit delta can never be -128
  a_dy_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> delta_y != 9'h180)
    else $error("delta_y out of range");

  // A fresh result traces back to an accepted input beat, through the input register and the result register
  a_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without matching input beat");

endmodule

bind mouse_packet_cursor_tracker mpct_checker #(
  .COORD_BITS (COORD_BITS)
) u_mpct_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .cursor_x    (cursor_x),
  .cursor_y    (cursor_y),
  .button_bits (button_bits),
  .delta_y     (delta_y)
);
